/* sv/rc4_pkg.sv */
// ---------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants for the RC4 stream cipher block.
// ---------------------------------------------------------------------------
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int ADDR_W     = $clog2(PERM_DEPTH);
  localparam int KEY_BYTES  = 16;
  localparam int KSEL_W     = $clog2(KEY_BYTES);
  localparam int REG_W      = 64;
  localparam int KEY_W      = KEY_BYTES * BYTE_W;
  localparam int CFG_ADDR_W = 1;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KSA_A,
    ST_KSA_B,
    ST_KSA_WA,
    ST_KSA_WB,
    ST_GEN_I,
    ST_GEN_J,
    ST_GEN_WI,
    ST_GEN_WJ,
    ST_OUT
  } rc4_state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT_GEN,
    OP_ACCEPT_KEY,
    OP_FILL,
    OP_KSA_A,
    OP_KSA_B,
    OP_KSA_WA,
    OP_KSA_WB,
    OP_GEN_I,
    OP_GEN_J,
    OP_GEN_WI,
    OP_GEN_WJ,
    OP_OUT
  } rc4_op_t;

  typedef struct packed {
    rc4_op_t op;
    logic    out_load;
  } rc4_cmd_t;

  typedef struct packed {
    logic a_last;
    logic out_free;
  } rc4_sts_t;

endpackage

/* sv/rc4_stream_cipher.sv */
// ---------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 stream cipher with a 128-bit key held in two configuration registers.
// ---------------------------------------------------------------------------
// Each accepted byte is XORed with the next RC4 keystream byte. A byte is
// processed with three reads and two swap writes on the 256 x 8
// permutation RAM, which has one read and one write port; the next byte
// is taken only once the block is back in its idle state. A byte flagged
// as first of a message, and the first byte after reset, first re-runs the
// key schedule: the identity permutation is loaded, then the 256 swap
// steps run. The result register lets the next byte be taken while the
// previous result waits.
// Write the key only while the block is idle; a new key takes effect at the
// next key schedule.
module rc4_stream_cipher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  logic                           in_tuser,   // [0] first_byte
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // [7:0] out_byte
  input  logic                           cfg_we,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rc4_pkg::REG_W-1:0]      cfg_wdata
);

  rc4_pkg::rc4_cmd_t cmd;
  rc4_pkg::rc4_sts_t sts;

  rc4_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .first_byte (in_tuser),
    .in_tready  (in_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  rc4_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .data_in    (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_data   (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

  // one byte in flight: an accepted transaction blocks further input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a byte is in flight");

  // results are only loaded into a free output register
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("output register overrun");

  // a first byte always starts the permutation fill
  a_rekey_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser) |=> (cmd.op == rc4_pkg::OP_FILL))
    else $error("first byte did not start key scheduling");

  // a result is loaded only with or after the second swap write of its byte
  a_load_point: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (cmd.op == rc4_pkg::OP_GEN_WJ || cmd.op == rc4_pkg::OP_OUT))
    else $error("output loaded outside the generation step");

endmodule

/* sv/rc4_ctrl.sv */
// ---------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key scheduling and keystream generation.
// ---------------------------------------------------------------------------
module rc4_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             first_byte,
  output logic             in_tready,
  input  rc4_pkg::rc4_sts_t sts,
  output rc4_pkg::rc4_cmd_t cmd
);

  rc4_pkg::rc4_state_t state_r, state_nxt;
  logic                keyed_r, keyed_nxt;
  logic                rekey;

  assign rekey     = first_byte || !keyed_r;
  assign in_tready = (state_r == rc4_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rc4_pkg::ST_IDLE;
      keyed_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      keyed_r <= keyed_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    keyed_nxt = keyed_r;
    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rekey ? rc4_pkg::ST_FILL : rc4_pkg::ST_GEN_J;
        end
      end
      rc4_pkg::ST_FILL: begin
        if (sts.a_last) state_nxt = rc4_pkg::ST_KSA_A;
      end
      rc4_pkg::ST_KSA_A:  state_nxt = rc4_pkg::ST_KSA_B;
      rc4_pkg::ST_KSA_B:  state_nxt = rc4_pkg::ST_KSA_WA;
      rc4_pkg::ST_KSA_WA: state_nxt = rc4_pkg::ST_KSA_WB;
      rc4_pkg::ST_KSA_WB: begin
        if (sts.a_last) begin
          state_nxt = rc4_pkg::ST_GEN_I;
          keyed_nxt = 1'b1;
        end else begin
          state_nxt = rc4_pkg::ST_KSA_A;
        end
      end
      rc4_pkg::ST_GEN_I:  state_nxt = rc4_pkg::ST_GEN_J;
      rc4_pkg::ST_GEN_J:  state_nxt = rc4_pkg::ST_GEN_WI;
      rc4_pkg::ST_GEN_WI: state_nxt = rc4_pkg::ST_GEN_WJ;
      rc4_pkg::ST_GEN_WJ: state_nxt = sts.out_free ? rc4_pkg::ST_IDLE : rc4_pkg::ST_OUT;
      rc4_pkg::ST_OUT: begin
        if (sts.out_free) state_nxt = rc4_pkg::ST_IDLE;
      end
      default: state_nxt = rc4_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.op       = rc4_pkg::OP_IDLE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      rc4_pkg::ST_IDLE: begin
        if (in_tvalid) cmd.op = rekey ? rc4_pkg::OP_ACCEPT_KEY : rc4_pkg::OP_ACCEPT_GEN;
      end
      rc4_pkg::ST_FILL:   cmd.op = rc4_pkg::OP_FILL;
      rc4_pkg::ST_KSA_A:  cmd.op = rc4_pkg::OP_KSA_A;
      rc4_pkg::ST_KSA_B:  cmd.op = rc4_pkg::OP_KSA_B;
      rc4_pkg::ST_KSA_WA: cmd.op = rc4_pkg::OP_KSA_WA;
      rc4_pkg::ST_KSA_WB: cmd.op = rc4_pkg::OP_KSA_WB;
      rc4_pkg::ST_GEN_I:  cmd.op = rc4_pkg::OP_GEN_I;
      rc4_pkg::ST_GEN_J:  cmd.op = rc4_pkg::OP_GEN_J;
      rc4_pkg::ST_GEN_WI: cmd.op = rc4_pkg::OP_GEN_WI;
      rc4_pkg::ST_GEN_WJ: begin
        cmd.op       = rc4_pkg::OP_GEN_WJ;
        cmd.out_load = sts.out_free;
      end
      rc4_pkg::ST_OUT: begin
        cmd.op       = rc4_pkg::OP_OUT;
        cmd.out_load = sts.out_free;
      end
      default: cmd.op = rc4_pkg::OP_IDLE;
    endcase
  end

endmodule

/* sv/rc4_dp.sv */
// ---------------------------------------------------------------------------
// rc4_dp
// Permutation memory, indices, key registers and output register.
// ---------------------------------------------------------------------------
module rc4_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [rc4_pkg::REG_W-1:0]         cfg_wdata,
  input  rc4_pkg::byte_t                    data_in,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output rc4_pkg::byte_t                    out_data,
  input  rc4_pkg::rc4_cmd_t                 cmd,
  output rc4_pkg::rc4_sts_t                 sts
);

  rc4_pkg::byte_t mem [rc4_pkg::PERM_DEPTH];

  logic [rc4_pkg::KEY_W-1:0] key_r;
  rc4_pkg::byte_t  rd_r;
  rc4_pkg::addr_t  rd_addr, wr_addr;
  rc4_pkg::byte_t  wr_data;
  logic            wr_en;

  rc4_pkg::addr_t  i_r, i_nxt, j_r, j_nxt, a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  rc4_pkg::byte_t  s1_r, s1_nxt, s2_r, s2_nxt, data_r, data_nxt, ks_r, ks_nxt;
  rc4_pkg::byte_t  out_r, out_nxt, ks_fwd, key_byte;
  logic            out_valid_r, out_valid_nxt;
  logic [rc4_pkg::KSEL_W-1:0] ksel;

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        rc4_pkg::REG_KEY_LOW:  key_r[rc4_pkg::REG_W-1:0]             <= cfg_wdata;
        rc4_pkg::REG_KEY_HIGH: key_r[rc4_pkg::KEY_W-1:rc4_pkg::REG_W] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ksel     = a_r[rc4_pkg::KSEL_W-1:0];
  assign key_byte = key_r[{ksel, 3'b000} +: rc4_pkg::BYTE_W];

  // the swap writes of the current byte are still pending when k is read
  assign ks_fwd = (k_r == j_r) ? s1_r :
                  (k_r == i_r) ? s2_r : rd_r;

  assign sts.a_last   = (a_r == rc4_pkg::addr_t'(rc4_pkg::PERM_DEPTH - 1));
  assign sts.out_free = !out_valid_r || out_tready;

  always_comb begin
    i_nxt    = i_r;
    j_nxt    = j_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    data_nxt = data_r;
    ks_nxt   = ks_r;
    out_nxt  = out_r;
    rd_addr  = i_r + 1'b1;
    wr_en    = 1'b0;
    wr_addr  = a_r;
    wr_data  = rd_r;
    unique case (cmd.op)
      rc4_pkg::OP_IDLE: ;
      rc4_pkg::OP_ACCEPT_GEN: begin
        data_nxt = data_in;
        i_nxt    = i_r + 1'b1;
      end
      rc4_pkg::OP_ACCEPT_KEY: begin
        data_nxt = data_in;
        a_nxt    = '0;
        b_nxt    = '0;
        i_nxt    = '0;
        j_nxt    = '0;
      end
      rc4_pkg::OP_FILL: begin
        wr_en   = 1'b1;
        wr_data = a_r;
        a_nxt   = a_r + 1'b1;
      end
      rc4_pkg::OP_KSA_A: rd_addr = a_r;
      rc4_pkg::OP_KSA_B: begin
        b_nxt   = b_r + rd_r + key_byte;
        rd_addr = b_nxt;
        s1_nxt  = rd_r;
      end
      rc4_pkg::OP_KSA_WA: begin
        wr_en = 1'b1;
      end
      rc4_pkg::OP_KSA_WB: begin
        wr_en   = 1'b1;
        wr_addr = b_r;
        wr_data = s1_r;
        a_nxt   = a_r + 1'b1;
      end
      rc4_pkg::OP_GEN_I: begin
        i_nxt = i_r + 1'b1;
      end
      rc4_pkg::OP_GEN_J: begin
        j_nxt   = j_r + rd_r;
        rd_addr = j_nxt;
        s1_nxt  = rd_r;
      end
      rc4_pkg::OP_GEN_WI: begin
        wr_en   = 1'b1;
        wr_addr = i_r;
        s2_nxt  = rd_r;
        k_nxt   = s1_r + rd_r;
        rd_addr = k_nxt;
      end
      rc4_pkg::OP_GEN_WJ: begin
        wr_en   = 1'b1;
        wr_addr = j_r;
        wr_data = s1_r;
        ks_nxt  = ks_fwd;
        if (cmd.out_load) out_nxt = data_r ^ ks_fwd;
      end
      rc4_pkg::OP_OUT: begin
        if (cmd.out_load) out_nxt = data_r ^ ks_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  // permutation memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r         <= '0;
      j_r         <= '0;
      a_r         <= '0;
      b_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    s1_r   <= s1_nxt;
    s2_r   <= s2_nxt;
    data_r <= data_nxt;
    ks_r   <= ks_nxt;
    out_r  <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_data   = out_r;

endmodule
